@@ rtl/sdmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sdmt_pkg;

  localparam int BUF_COLS       = 256;
  localparam int WIN_COLS       = 20;
  localparam int GLYPH_COLS     = 5;
  localparam int CHARS_PER_WIN  = 4;
  localparam int QUEUE_DEPTH    = 4;

  localparam int ADDR_W  = $clog2(BUF_COLS);
  localparam int POS_W   = $clog2(BUF_COLS + 1);
  localparam int ISS_W   = $clog2(WIN_COLS + 1);
  localparam int CNT_W   = $clog2(CHARS_PER_WIN * GLYPH_COLS + 1);
  localparam int CL_W    = $clog2(CHARS_PER_WIN + 1);
  localparam int ROW_W   = 8 * GLYPH_COLS;
  localparam int DWELL_W = 16;
  localparam int COL_IDX_W = 5;
  localparam int PADDR_W = 5;

  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7A;

  localparam logic [DWELL_W-1:0] LONG_DWELL_RST  = 16'd800;
  localparam logic [DWELL_W-1:0] SHORT_DWELL_RST = 16'd250;
  localparam logic [DWELL_W-1:0] RAW_DWELL_RST   = 16'd100;
  localparam logic [DWELL_W-1:0] BLINK_TICKS_RST = 16'd80;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_BLINK    = 3'd1,
    MODE_TEXT     = 3'd2,
    MODE_RAW      = 3'd3,
    MODE_END_TEXT = 3'd4,
    MODE_END_RAW  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    REG_SCROLL = 3'd0,
    REG_LONG   = 3'd1,
    REG_SHORT  = 3'd2,
    REG_RAW    = 3'd3,
    REG_BLINK  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    K_TICK,
    K_BLINK,
    K_GLYPH,
    K_CHAR_SKIP,
    K_RAW,
    K_END_TEXT,
    K_END_RAW
  } kind_t;

  // payload: glyph columns with the leftmost column in the top byte,
  // or the raw column byte in the low byte
  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic               scroll_en;
    logic [DWELL_W-1:0] long_dwell;
    logic [DWELL_W-1:0] short_dwell;
    logic [DWELL_W-1:0] raw_dwell;
    logic [DWELL_W-1:0] blink_ticks;
  } cfg_t;

  function automatic logic [ROW_W-1:0] glyph_row(input logic [6:0] idx);
    logic [ROW_W-1:0] row;
    case (idx)
      7'd0:  row = 40'h00_00_00_00_00;
      7'd1:  row = 40'h00_00_2F_00_00;
      7'd2:  row = 40'h00_07_00_07_00;
      7'd3:  row = 40'h14_7F_14_7F_14;
      7'd4:  row = 40'h24_2A_7F_2A_12;
      7'd5:  row = 40'hC4_C8_10_26_46;
      7'd6:  row = 40'h36_49_55_22_50;
      7'd7:  row = 40'h00_05_03_00_00;
      7'd8:  row = 40'h00_1C_22_41_00;
      7'd9:  row = 40'h00_41_22_1C_00;
      7'd10: row = 40'h14_08_3E_08_14;
      7'd11: row = 40'h08_08_3E_08_08;
      7'd12: row = 40'h00_00_50_30_00;
      7'd13: row = 40'h10_10_10_10_10;
      7'd14: row = 40'h00_60_60_00_00;
      7'd15: row = 40'h20_10_08_04_02;
      7'd16: row = 40'h3E_51_49_45_3E;
      7'd17: row = 40'h00_42_7F_40_00;
      7'd18: row = 40'h42_61_51_49_46;
      7'd19: row = 40'h21_41_45_4B_31;
      7'd20: row = 40'h18_14_12_7F_10;
      7'd21: row = 40'h27_45_45_45_39;
      7'd22: row = 40'h3C_4A_49_49_30;
      7'd23: row = 40'h01_71_09_05_03;
      7'd24: row = 40'h36_49_49_49_36;
      7'd25: row = 40'h06_49_49_29_1E;
      7'd26: row = 40'h00_36_36_00_00;
      7'd27: row = 40'h00_56_36_00_00;
      7'd28: row = 40'h08_14_22_41_00;
      7'd29: row = 40'h14_14_14_14_14;
      7'd30: row = 40'h00_41_22_14_08;
      7'd31: row = 40'h02_01_51_09_06;
      7'd32: row = 40'h32_49_59_51_3E;
      7'd33: row = 40'h7E_11_11_11_7E;
      7'd34: row = 40'h7F_49_49_49_36;
      7'd35: row = 40'h3E_41_41_41_22;
      7'd36: row = 40'h7F_41_41_22_1C;
      7'd37: row = 40'h7F_49_49_49_41;
      7'd38: row = 40'h7F_09_09_09_01;
      7'd39: row = 40'h3E_41_49_49_7A;
      7'd40: row = 40'h7F_08_08_08_7F;
      7'd41: row = 40'h00_41_7F_41_00;
      7'd42: row = 40'h20_40_41_3F_01;
      7'd43: row = 40'h7F_08_14_22_41;
      7'd44: row = 40'h7F_40_40_40_40;
      7'd45: row = 40'h7F_02_0C_02_7F;
      7'd46: row = 40'h7F_04_08_10_7F;
      7'd47: row = 40'h3E_41_41_41_3E;
      7'd48: row = 40'h7F_09_09_09_06;
      7'd49: row = 40'h3E_41_51_21_5E;
      7'd50: row = 40'h7F_09_19_29_46;
      7'd51: row = 40'h46_49_49_49_31;
      7'd52: row = 40'h01_01_7F_01_01;
      7'd53: row = 40'h3F_40_40_40_3F;
      7'd54: row = 40'h1F_20_40_20_1F;
      7'd55: row = 40'h3F_40_38_40_3F;
      7'd56: row = 40'h63_14_08_14_63;
      7'd57: row = 40'h07_08_70_08_07;
      7'd58: row = 40'h61_51_49_45_43;
      7'd59: row = 40'h00_7F_41_41_00;
      7'd60: row = 40'h55_2A_55_2A_55;
      7'd61: row = 40'h00_41_41_7F_00;
      7'd62: row = 40'h04_02_01_02_04;
      7'd63: row = 40'h40_40_40_40_40;
      7'd64: row = 40'h00_01_02_04_00;
      7'd65: row = 40'h20_54_54_54_78;
      7'd66: row = 40'h7F_48_44_44_38;
      7'd67: row = 40'h38_44_44_44_20;
      7'd68: row = 40'h38_44_44_48_7F;
      7'd69: row = 40'h38_54_54_54_18;
      7'd70: row = 40'h08_7E_09_01_02;
      7'd71: row = 40'h0C_52_52_52_3E;
      7'd72: row = 40'h7F_08_04_04_78;
      7'd73: row = 40'h00_44_7D_40_00;
      7'd74: row = 40'h20_40_44_3D_00;
      7'd75: row = 40'h7F_10_28_44_00;
      7'd76: row = 40'h00_41_7F_40_00;
      7'd77: row = 40'h7C_04_18_04_78;
      7'd78: row = 40'h7C_08_04_04_78;
      7'd79: row = 40'h38_44_44_44_38;
      7'd80: row = 40'h7C_14_14_14_08;
      7'd81: row = 40'h08_14_14_18_7C;
      7'd82: row = 40'h7C_08_04_04_08;
      7'd83: row = 40'h48_54_54_54_20;
      7'd84: row = 40'h04_3F_44_40_20;
      7'd85: row = 40'h3C_40_40_20_7C;
      7'd86: row = 40'h1C_20_40_20_1C;
      7'd87: row = 40'h3C_40_30_40_3C;
      7'd88: row = 40'h44_28_10_28_44;
      7'd89: row = 40'h0C_50_50_50_3C;
      7'd90: row = 40'h44_64_54_4C_44;
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sdmt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sdmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sdmt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sdmt_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output sdmt_pkg::cmd_t        q_cmd
);

  logic keep;

  assign in_tready = !q_full;

  always_comb begin
    keep          = 1'b1;
    q_cmd.kind    = sdmt_pkg::K_TICK;
    q_cmd.payload = sdmt_pkg::ROW_W'(in_tdata);
    case (in_tuser)
      sdmt_pkg::MODE_TICK:  q_cmd.kind = sdmt_pkg::K_TICK;
      sdmt_pkg::MODE_BLINK: q_cmd.kind = sdmt_pkg::K_BLINK;
      sdmt_pkg::MODE_TEXT: begin
        if (in_tdata inside {[sdmt_pkg::GLYPH_FIRST:sdmt_pkg::GLYPH_LAST]}) begin
          q_cmd.kind    = sdmt_pkg::K_GLYPH;
          q_cmd.payload = sdmt_pkg::glyph_row(7'(in_tdata - sdmt_pkg::GLYPH_FIRST));
        end else begin
          // no columns, but it still counts as a character
          q_cmd.kind = sdmt_pkg::K_CHAR_SKIP;
        end
      end
      sdmt_pkg::MODE_RAW:      q_cmd.kind = sdmt_pkg::K_RAW;
      sdmt_pkg::MODE_END_TEXT: q_cmd.kind = sdmt_pkg::K_END_TEXT;
      sdmt_pkg::MODE_END_RAW:  q_cmd.kind = sdmt_pkg::K_END_RAW;
      default: keep = 1'b0;
    endcase
  end

  // drop unused modes here; they never reach the back end
  assign q_push = in_tvalid && in_tready && keep;

endmodule
`default_nettype wire

@@ rtl/sdmt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sdmt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sdmt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sdmt_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int PW = $clog2(sdmt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(sdmt_pkg::QUEUE_DEPTH + 1);

  sdmt_pkg::cmd_t mem_r [sdmt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full    = (count_r == CW'(sdmt_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(sdmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(sdmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/sdmt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sdmt_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sdmt_pkg::cfg_t                     cfg,
  input  logic                               q_empty,
  input  sdmt_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_bits,
  output logic [sdmt_pkg::COL_IDX_W-1:0]     out_idx,
  output logic                               out_last
);

  localparam int AW   = sdmt_pkg::ADDR_W;
  localparam int PW   = sdmt_pkg::POS_W;
  localparam int IW   = sdmt_pkg::ISS_W;
  localparam int NW   = sdmt_pkg::CNT_W;
  localparam int LW   = sdmt_pkg::CL_W;
  localparam int RW   = sdmt_pkg::ROW_W;
  localparam int DW   = sdmt_pkg::DWELL_W;
  localparam int XW   = sdmt_pkg::COL_IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_APPEND, S_FRAME} state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [LW-1:0] cl_r, cl_nxt;
  logic [PW-1:0] ce_r, ce_nxt;
  logic [PW-1:0] ws_r, ws_nxt;
  logic          raw_r, raw_nxt;
  logic [DW-1:0] dwell_r, dwell_nxt;
  logic [DW-1:0] lim_r, lim_nxt;
  logic [DW-1:0] blrem_r, blrem_nxt;
  logic          blpend_r, blpend_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] sh_r, sh_nxt;
  logic          fin_r, fin_nxt;
  logic [PW-1:0] fb_r, fb_nxt;
  logic          blank_r, blank_nxt;
  logic [IW-1:0] iss_r, iss_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          rd_zero_r, rd_zero_nxt;
  logic [XW-1:0] rd_col_r, rd_col_nxt;
  logic          out_v_r, out_v_nxt;
  logic [7:0]    out_bits_r, out_bits_nxt;
  logic [XW-1:0] out_idx_r, out_idx_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          adv;
  logic          room;
  logic [PW:0]   pos;
  logic          wrap;
  logic [PW-1:0] ws_eff, ws_base;
  logic          edge_win;
  logic [DW-1:0] lim_new, lim_use, dc1;
  logic [LW-1:0] pad_chars;
  logic [NW-1:0] pad_cnt;

  sdmt_ram #(.WIDTH(8), .DEPTH(sdmt_pkg::BUF_COLS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign room = (wp_r < PW'(sdmt_pkg::BUF_COLS));
  assign adv  = !out_v_r || out_ready;
  assign pos  = {1'b0, fb_r} + (PW + 1)'(iss_r);

  // tick window selection: wrap first, then pick the dwell for this window
  assign wrap     = ({1'b0, ws_r} + (PW + 1)'(sdmt_pkg::WIN_COLS)) > {1'b0, ce_r};
  assign ws_eff   = wrap ? '0 : ws_r;
  assign edge_win = (ws_eff == '0) ||
                    (({1'b0, ws_eff} + (PW + 1)'(sdmt_pkg::WIN_COLS)) == {1'b0, ce_r});
  assign lim_new  = raw_r ? cfg.raw_dwell : (edge_win ? cfg.long_dwell : cfg.short_dwell);
  assign lim_use  = (dwell_r == '0) ? lim_new : lim_r;
  assign ws_base  = (dwell_r == '0) ? ws_eff : ws_r;
  assign dc1      = dwell_r + 1'b1;

  assign pad_chars = LW'(sdmt_pkg::CHARS_PER_WIN) - cl_r;
  assign pad_cnt   = NW'(pad_chars) * NW'(sdmt_pkg::GLYPH_COLS);

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    cl_nxt       = cl_r;
    ce_nxt       = ce_r;
    ws_nxt       = ws_r;
    raw_nxt      = raw_r;
    dwell_nxt    = dwell_r;
    lim_nxt      = lim_r;
    blrem_nxt    = blrem_r;
    blpend_nxt   = blpend_r;
    cnt_nxt      = cnt_r;
    sh_nxt       = sh_r;
    fin_nxt      = fin_r;
    fb_nxt       = fb_r;
    blank_nxt    = blank_r;
    iss_nxt      = iss_r;
    rd_v_nxt     = rd_v_r;
    rd_zero_nxt  = rd_zero_r;
    rd_col_nxt   = rd_col_r;
    out_v_nxt    = out_v_r;
    out_bits_nxt = out_bits_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_waddr    = wp_r[AW-1:0];
    ram_wdata    = sh_r[RW-1 -: 8];
    ram_re       = 1'b0;
    ram_raddr    = pos[AW-1:0];
    q_pop        = 1'b0;

    if (adv) begin
      out_v_nxt = 1'b0;
    end
    if (adv && rd_v_r) begin
      out_v_nxt    = 1'b1;
      out_bits_nxt = rd_zero_r ? 8'h00 : ram_rdata;
      out_idx_nxt  = rd_col_r;
      out_last_nxt = (rd_col_r == XW'(sdmt_pkg::WIN_COLS - 1));
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            sdmt_pkg::K_TICK: begin
              if (blrem_r != '0) begin
                if (blpend_r) begin
                  blpend_nxt = 1'b0;
                  blank_nxt  = 1'b1;
                  iss_nxt    = '0;
                  state_nxt  = S_FRAME;
                end
                blrem_nxt = blrem_r - 1'b1;
              end else begin
                if (dwell_r == '0) begin
                  lim_nxt   = lim_new;
                  fb_nxt    = ws_eff;
                  blank_nxt = 1'b0;
                  iss_nxt   = '0;
                  state_nxt = S_FRAME;
                end
                ws_nxt    = ws_base;
                dwell_nxt = dc1;
                if (dc1 >= lim_use) begin
                  dwell_nxt = '0;
                  if (cfg.scroll_en) begin
                    ws_nxt = ws_base + PW'(sdmt_pkg::GLYPH_COLS);
                  end
                end
              end
            end
            sdmt_pkg::K_BLINK: begin
              blpend_nxt = 1'b1;
              blrem_nxt  = cfg.blink_ticks;
              dwell_nxt  = '0;
            end
            sdmt_pkg::K_GLYPH: begin
              sh_nxt    = q_cmd.payload;
              cnt_nxt   = NW'(sdmt_pkg::GLYPH_COLS);
              fin_nxt   = 1'b0;
              state_nxt = S_APPEND;
              if (cl_r < LW'(sdmt_pkg::CHARS_PER_WIN)) begin
                cl_nxt = cl_r + 1'b1;
              end
            end
            sdmt_pkg::K_CHAR_SKIP: begin
              if (cl_r < LW'(sdmt_pkg::CHARS_PER_WIN)) begin
                cl_nxt = cl_r + 1'b1;
              end
            end
            sdmt_pkg::K_RAW: begin
              ram_wdata = q_cmd.payload[7:0];
              if (room) begin
                ram_we = 1'b1;
                wp_nxt = wp_r + 1'b1;
              end
            end
            sdmt_pkg::K_END_TEXT: begin
              if (cl_r < LW'(sdmt_pkg::CHARS_PER_WIN)) begin
                // pad the short text with blank characters, then close
                sh_nxt    = '0;
                cnt_nxt   = pad_cnt;
                fin_nxt   = 1'b1;
                state_nxt = S_APPEND;
              end else begin
                ce_nxt    = wp_r;
                ws_nxt    = '0;
                raw_nxt   = 1'b0;
                dwell_nxt = '0;
                wp_nxt    = '0;
                cl_nxt    = '0;
              end
            end
            sdmt_pkg::K_END_RAW: begin
              ce_nxt    = wp_r;
              ws_nxt    = '0;
              raw_nxt   = 1'b1;
              dwell_nxt = '0;
              wp_nxt    = '0;
              cl_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_APPEND: begin
        if (room) begin
          ram_we = 1'b1;
          wp_nxt = wp_r + 1'b1;
        end
        sh_nxt  = sh_r << 8;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          state_nxt = S_IDLE;
          if (fin_r) begin
            ce_nxt    = room ? wp_r + 1'b1 : wp_r;
            ws_nxt    = '0;
            raw_nxt   = 1'b0;
            dwell_nxt = '0;
            wp_nxt    = '0;
            cl_nxt    = '0;
          end
        end
      end

      S_FRAME: begin
        // read stage moves when the output slot frees up or it is empty
        if (adv || !rd_v_r) begin
          if (iss_r < IW'(sdmt_pkg::WIN_COLS)) begin
            ram_re      = 1'b1;
            rd_v_nxt    = 1'b1;
            rd_zero_nxt = blank_r || (pos >= {1'b0, ce_r});
            rd_col_nxt  = XW'(iss_r);
            iss_nxt     = iss_r + 1'b1;
          end else begin
            rd_v_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wp_r       <= '0;
      cl_r       <= '0;
      ce_r       <= '0;
      ws_r       <= '0;
      raw_r      <= 1'b0;
      dwell_r    <= '0;
      lim_r      <= '0;
      blrem_r    <= '0;
      blpend_r   <= 1'b0;
      cnt_r      <= '0;
      sh_r       <= '0;
      fin_r      <= 1'b0;
      fb_r       <= '0;
      blank_r    <= 1'b0;
      iss_r      <= '0;
      rd_v_r     <= 1'b0;
      rd_zero_r  <= 1'b0;
      rd_col_r   <= '0;
      out_v_r    <= 1'b0;
      out_bits_r <= '0;
      out_idx_r  <= '0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      cl_r       <= cl_nxt;
      ce_r       <= ce_nxt;
      ws_r       <= ws_nxt;
      raw_r      <= raw_nxt;
      dwell_r    <= dwell_nxt;
      lim_r      <= lim_nxt;
      blrem_r    <= blrem_nxt;
      blpend_r   <= blpend_nxt;
      cnt_r      <= cnt_nxt;
      sh_r       <= sh_nxt;
      fin_r      <= fin_nxt;
      fb_r       <= fb_nxt;
      blank_r    <= blank_nxt;
      iss_r      <= iss_nxt;
      rd_v_r     <= rd_v_nxt;
      rd_zero_r  <= rd_zero_nxt;
      rd_col_r   <= rd_col_nxt;
      out_v_r    <= out_v_nxt;
      out_bits_r <= out_bits_nxt;
      out_idx_r  <= out_idx_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_bits  = out_bits_r;
  assign out_idx   = out_idx_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

@@ rtl/scrolling_dot_matrix_text_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// in_       request    tvalid/tready      tuser = mode, tdata = data
// out_      result     tvalid/tready      tdata = column_bits, column_index; tlast = frame_last
// cfg_      APB write  psel/penable/pwrite  5 registers at byte address 4*index
//
// A tick that shows a frame is decoded first; its columns then come one per cycle, unless the
// result side stalls, from the column store's registered read port, and the read stage drains.
// A text character makes five store writes while the store has room, an end of text pads
// with blank columns up to four characters, and every other request is done when decoded.
// Synchronous active-low reset; the column store is not cleared. A stalled result holds in
// the output register while up to four requests wait in the command queue.
module scrolling_dot_matrix_text_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,    // [7:0] data
  input  logic [2:0]                        in_tuser,    // [2:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,   // [7:0] column_bits, [12:8] column_index
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sdmt_pkg::PADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  sdmt_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  sdmt_pkg::reg_idx_t cfg_idx;

  logic           q_push, q_pop, q_full, q_empty;
  sdmt_pkg::cmd_t push_cmd, pop_cmd;

  logic [7:0]                     col_bits;
  logic [sdmt_pkg::COL_IDX_W-1:0] col_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = sdmt_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scroll_en   <= 1'b1;
      cfg_r.long_dwell  <= sdmt_pkg::LONG_DWELL_RST;
      cfg_r.short_dwell <= sdmt_pkg::SHORT_DWELL_RST;
      cfg_r.raw_dwell   <= sdmt_pkg::RAW_DWELL_RST;
      cfg_r.blink_ticks <= sdmt_pkg::BLINK_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sdmt_pkg::REG_SCROLL: cfg_r.scroll_en   <= cfg_pwdata[0];
        sdmt_pkg::REG_LONG:   cfg_r.long_dwell  <= cfg_pwdata[15:0];
        sdmt_pkg::REG_SHORT:  cfg_r.short_dwell <= cfg_pwdata[15:0];
        sdmt_pkg::REG_RAW:    cfg_r.raw_dwell   <= cfg_pwdata[15:0];
        sdmt_pkg::REG_BLINK:  cfg_r.blink_ticks <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sdmt_pkg::REG_SCROLL: cfg_prdata = 32'(cfg_r.scroll_en);
      sdmt_pkg::REG_LONG:   cfg_prdata = 32'(cfg_r.long_dwell);
      sdmt_pkg::REG_SHORT:  cfg_prdata = 32'(cfg_r.short_dwell);
      sdmt_pkg::REG_RAW:    cfg_prdata = 32'(cfg_r.raw_dwell);
      sdmt_pkg::REG_BLINK:  cfg_prdata = 32'(cfg_r.blink_ticks);
      default:              cfg_prdata = '0;
    endcase
  end

  sdmt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sdmt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sdmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bits  (col_bits),
    .out_idx   (col_idx),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, col_idx, col_bits};

endmodule
`default_nettype wire

@@ rtl/sdmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sdmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled column holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:8] <= 5'd19) && (out_tdata[15:13] == 3'b000))
    else $error("column index out of frame");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[12:8] == 5'd19)))
    else $error("frame end flag does not match column index");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind scrolling_dot_matrix_text_engine sdmt_checker u_sdmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

@@ bench/tb_scrolling_dot_matrix_text_engine.sv @@
`timescale 1ns / 1ps
module tb_scrolling_dot_matrix_text_engine;
  import sdmt_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic ZERO_FRAME = 1'b1;
  localparam logic PREDICTED  = 1'b0;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 120;
  localparam int TAIL_CYCLES    = 60;
  localparam int STALL_LIMIT    = 3000;

  typedef struct packed {
    logic [7:0] bits;
    logic [4:0] index;
    logic       last;
  } column_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data;
    logic       zero_frame;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_zero_frame = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scrolling_dot_matrix_text_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 5-column font from space to 'z', leftmost column in the top byte
  logic [39:0] font_rows [91] = '{
    40'h00_00_00_00_00, 40'h00_00_2F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'hC4_C8_10_26_46, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_00_50_30_00, 40'h10_10_10_10_10, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_59_51_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h55_2A_55_2A_55, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44
  };

  stim_row_t directed_rows [25] = '{
    {MODE_TICK,     8'h00, ZERO_FRAME},  // nothing loaded yet
    {MODE_TEXT,     "A",   PREDICTED},
    {MODE_TEXT,     8'h7F, PREDICTED},   // no glyph, still counts
    {MODE_TEXT,     " ",   PREDICTED},
    {MODE_TEXT,     "z",   PREDICTED},
    {MODE_TEXT,     8'h1F, PREDICTED},   // fifth char, count saturates
    {MODE_END_TEXT, 8'h00, PREDICTED},
    {MODE_TICK,     8'hFF, PREDICTED},
    {MODE_TICK,     8'h00, PREDICTED},   // window runs past content, wraps
    {MODE_TEXT,     8'h00, PREDICTED},
    {MODE_TEXT,     8'hFF, PREDICTED},
    {MODE_END_TEXT, 8'hFF, PREDICTED},   // pads two blank chars
    {MODE_RAW,      8'hFF, PREDICTED},
    {MODE_RAW,      8'h00, PREDICTED},
    {MODE_RAW,      8'hA5, PREDICTED},
    {MODE_END_RAW,  8'h5A, PREDICTED},
    {MODE_TICK,     8'h00, PREDICTED},
    {MODE_BLINK,    8'h00, PREDICTED},
    {MODE_TICK,     8'h00, ZERO_FRAME},  // blank frame of the blink
    {MODE_TICK,     8'h00, PREDICTED},   // blink pause, no frame
    {MODE_TICK,     8'h00, PREDICTED},
    {MODE_SPARE_LO, 8'h55, PREDICTED},
    {MODE_SPARE_HI, 8'hAA, PREDICTED},
    {MODE_END_TEXT, 8'h00, PREDICTED},   // empty text: four blank chars
    {MODE_TICK,     8'h00, ZERO_FRAME}
  };

  // display state as seen from the outside
  logic        scroll_on;
  logic [15:0] long_ticks, short_ticks, raw_ticks, blink_len;
  logic [7:0]  column_mem [BUF_COLS];
  int unsigned write_ptr, chars_seen, content_len, window_pos;
  logic        showing_raw, blank_due;
  logic [15:0] dwell_ticks, dwell_target, blink_left;

  column_t expected_columns [$];
  int      mismatches = 0;
  int      requests_sent = 0;
  int      stalled_cycles = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;
  bit      calm = 1'b0;
  bit      rx_hold_request = 1'b0;

  initial begin
    scroll_on = 1'b1;
    long_ticks = LONG_DWELL_RST;
    short_ticks = SHORT_DWELL_RST;
    raw_ticks = RAW_DWELL_RST;
    blink_len = BLINK_TICKS_RST;
    foreach (column_mem[k]) column_mem[k] = 8'h00;
    write_ptr = 0; chars_seen = 0; content_len = 0; window_pos = 0;
    showing_raw = 1'b0; blank_due = 1'b0;
    dwell_ticks = '0; dwell_target = '0; blink_left = '0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 6) != 0) return 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
    return rand_byte();
  endfunction

  task automatic append_column(input logic [7:0] value);
    if (write_ptr < BUF_COLS) begin
      column_mem[write_ptr] = value;
      write_ptr++;
    end
  endtask

  task automatic push_frame(input logic blank);
    column_t col;
    for (int i = 0; i < WIN_COLS; i++) begin
      col.bits = (!blank && window_pos + i < content_len) ? column_mem[window_pos + i] : 8'h00;
      col.index = 5'(i);
      col.last = (i == WIN_COLS - 1);
      expected_columns.push_back(col);
    end
  endtask

  task automatic finish_load(input logic raw);
    content_len = write_ptr;
    window_pos = 0;
    showing_raw = raw;
    dwell_ticks = '0;
    write_ptr = 0;
    chars_seen = 0;
  endtask

  // Works out the frame columns a request produces and queues them.
  task automatic predict_display(input logic [2:0] mode, input logic [7:0] data,
                                 input logic zero_frame);
    case (mode)
      MODE_TICK: begin
        if (blink_left != 0) begin
          if (blank_due) begin
            push_frame(1'b1);
            blank_due = 1'b0;
          end
          blink_left = blink_left - 16'd1;
        end else begin
          if (dwell_ticks == 0) begin
            if (window_pos + WIN_COLS > content_len) window_pos = 0;
            if (showing_raw) dwell_target = raw_ticks;
            else if (window_pos == 0 || content_len - window_pos == WIN_COLS)
              dwell_target = long_ticks;
            else dwell_target = short_ticks;
            push_frame(zero_frame);
          end
          dwell_ticks = dwell_ticks + 16'd1;
          if (dwell_ticks >= dwell_target) begin
            dwell_ticks = '0;
            if (scroll_on) window_pos += GLYPH_COLS;
          end
        end
      end
      MODE_BLINK: begin
        blank_due = 1'b1;
        blink_left = blink_len;
        dwell_ticks = '0;
      end
      MODE_TEXT: begin
        if (data >= GLYPH_FIRST && data <= GLYPH_LAST)
          for (int j = 0; j < GLYPH_COLS; j++)
            append_column(font_rows[data - GLYPH_FIRST][39 - 8 * j -: 8]);
        if (chars_seen < CHARS_PER_WIN) chars_seen++;
      end
      MODE_RAW: append_column(data);
      MODE_END_TEXT: begin
        while (chars_seen < CHARS_PER_WIN) begin
          for (int j = 0; j < GLYPH_COLS; j++) append_column(8'h00);
          chars_seen++;
        end
        finish_load(1'b0);
      end
      MODE_END_RAW: finish_load(1'b1);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    column_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_columns.size() == 0) begin
          $error("unexpected column: tdata %h, tlast %b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = expected_columns.pop_front();
          if (out_tdata[7:0] !== want.bits) begin
            $error("column_bits: expected %h, got %h", want.bits, out_tdata[7:0]);
            mismatches++;
          end
          if (out_tdata[12:8] !== want.index) begin
            $error("column_index: expected %0d, got %0d", want.index, out_tdata[12:8]);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("frame_last: expected %b, got %b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_display(in_tuser, in_tdata, in_zero_frame);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $error("no progress for %0d cycles, %0d columns outstanding",
               STALL_LIMIT, expected_columns.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (rx_hold_request) begin
      rx_hold_request = 1'b0;
      out_tready <= 1'b0;
      repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
    end else if (!calm && rx_gaps && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_request(input logic [2:0] mode, input logic [7:0] data,
                              input logic zero_frame = 1'b0);
    if (!calm && tx_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tuser <= mode;
    in_tdata <= data;
    in_zero_frame <= zero_frame;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (mode <= MODE_END_RAW) requests_sent++;
  endtask

  // Hold off until every frame is out and the queued loads have settled.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (expected_columns.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_register(input reg_idx_t idx, input logic [15:0] want);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== want) begin
      $error("register %s: expected %h, got %h", idx.name(), want, cfg_prdata[15:0]);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    // bus goes idle before the next access
    @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0000, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    case (idx)
      REG_SCROLL: scroll_on = value[0];
      REG_LONG:   long_ticks = value;
      REG_SHORT:  short_ticks = value;
      REG_RAW:    raw_ticks = value;
      REG_BLINK:  blink_len = value;
      default: ;
    endcase
    check_register(idx, (idx == REG_SCROLL) ? {15'h0000, value[0]} : value);
  endtask

  // mostly short dwells so frames come often, now and then a long one
  task automatic write_random_config();
    write_register(REG_SCROLL, 16'($urandom_range(0, 1)));
    write_register(REG_LONG, ($urandom_range(0, 4) == 0) ?
                   16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 4)));
    write_register(REG_SHORT, 16'($urandom_range(1, 4)));
    write_register(REG_RAW, ($urandom_range(0, 4) == 0) ?
                   16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 3)));
    write_register(REG_BLINK, 16'($urandom_range(1, 4)));
  endtask

  task automatic drive_random_traffic(input int target);
    int pick;
    if (!calm) begin
      tx_gaps = ($urandom_range(0, 2) != 0);
      rx_gaps = ($urandom_range(0, 2) != 0);
    end
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 4)) push_request(MODE_TICK, rand_byte());
      end else if (pick < 60) begin
        // text load, ticks mixed in so the old content keeps showing
        repeat ($urandom_range(0, 6)) begin
          push_request(MODE_TEXT, pick_char());
          if ($urandom_range(0, 4) == 0) push_request(MODE_TICK, rand_byte());
        end
        if ($urandom_range(0, 9) != 0) push_request(MODE_END_TEXT, rand_byte());
      end else if (pick < 75) begin
        repeat ($urandom_range(0, 24)) push_request(MODE_RAW, rand_byte());
        if ($urandom_range(0, 9) != 0) push_request(MODE_END_RAW, rand_byte());
      end else if (pick < 85) begin
        push_request(MODE_BLINK, rand_byte());
      end else if (pick < 90) begin
        push_request($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO, rand_byte());
      end else begin
        push_request(3'($urandom_range(MODE_TICK, MODE_END_RAW)), rand_byte());
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_register(REG_SCROLL, 16'd1);
    check_register(REG_LONG, LONG_DWELL_RST);
    check_register(REG_SHORT, SHORT_DWELL_RST);
    check_register(REG_RAW, RAW_DWELL_RST);
    check_register(REG_BLINK, BLINK_TICKS_RST);

    write_register(REG_SCROLL, 16'd1);
    write_register(REG_LONG, 16'd1);
    write_register(REG_SHORT, 16'd2);
    write_register(REG_RAW, 16'd0);  // zero dwell: every window lasts one tick
    write_register(REG_BLINK, 16'd2);
    foreach (directed_rows[r])
      push_request(directed_rows[r].mode, directed_rows[r].data, directed_rows[r].zero_frame);
    wait_until_drained();

    write_register(REG_SCROLL, 16'd0);
    write_register(REG_LONG, 16'hFFFF);
    write_register(REG_SHORT, 16'hFFFF);
    write_register(REG_RAW, 16'hFFFF);
    write_register(REG_BLINK, 16'hFFFF);
    drive_random_traffic(requests_sent + 20);
    wait_until_drained();

    // overfill the store, then step the window through all of it
    write_register(REG_SCROLL, 16'd1);
    write_register(REG_LONG, 16'd1);
    write_register(REG_SHORT, 16'd1);
    write_register(REG_RAW, 16'd1);
    write_register(REG_BLINK, 16'd1);
    repeat (54) push_request(MODE_TEXT, 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST)));
    push_request(MODE_END_TEXT, rand_byte());
    repeat (50) push_request(MODE_TICK, rand_byte());
    drive_random_traffic(requests_sent + 10);
    wait_until_drained();

    // stall the result side while frames keep being requested
    rx_hold_request = 1'b1;
    repeat (10) push_request(MODE_TICK, rand_byte());
    drive_random_traffic(requests_sent + 5);
    wait_until_drained();

    write_random_config();
    drive_random_traffic(requests_sent + 15);
    wait_until_drained();
    write_random_config();
    drive_random_traffic(requests_sent + 15);
    wait_until_drained();
    write_random_config();
    calm = 1'b1;
    drive_random_traffic(requests_sent + 25);

    in_tvalid <= 1'b0;
    while (expected_columns.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ scrolling_dot_matrix_text_engine.f @@
rtl/sdmt_pkg.sv
rtl/sdmt_ram.sv
rtl/sdmt_front.sv
rtl/sdmt_queue.sv
rtl/sdmt_back.sv
rtl/scrolling_dot_matrix_text_engine.sv
rtl/sdmt_checker.sv
bench/tb_scrolling_dot_matrix_text_engine.sv
